// ===== hdl/frc_pkg.sv =====
`timescale 1ns / 1ps

package frc_pkg;

   localparam int SEQ_WIDTH    = 16;
   localparam int ID_WIDTH     = 8;
   localparam int OFFSET_WIDTH = 16;
   localparam int SIZE_WIDTH   = 16;
   localparam int COUNT_WIDTH  = 16;

   localparam int OFFSET_BITS_DEFAULT = 16;

   // sticky error bit positions, one per check
   localparam int ERR_SEQ    = 0;
   localparam int ERR_ID     = 1;
   localparam int ERR_FLAG   = 2;
   localparam int ERR_LENGTH = 3;
   localparam int ERR_OFFSET = 4;
   localparam int ERR_COUNT  = 5;

   typedef enum logic [2:0] {
      VERDICT_OK     = 3'd0,
      VERDICT_SEQ    = 3'd1,
      VERDICT_ID     = 3'd2,
      VERDICT_FLAG   = 3'd3,
      VERDICT_LENGTH = 3'd4,
      VERDICT_OFFSET = 3'd5
   } verdict_type;

   typedef logic [ERR_COUNT-1:0] err_flags_type;

   // lowest-numbered failed check wins
   function automatic verdict_type lowest_error(input err_flags_type flags);
      verdict_type v;
      if (flags[ERR_SEQ]) begin
         v = VERDICT_SEQ;
      end else if (flags[ERR_ID]) begin
         v = VERDICT_ID;
      end else if (flags[ERR_FLAG]) begin
         v = VERDICT_FLAG;
      end else if (flags[ERR_LENGTH]) begin
         v = VERDICT_LENGTH;
      end else if (flags[ERR_OFFSET]) begin
         v = VERDICT_OFFSET;
      end else begin
         v = VERDICT_OK;
      end
      return v;
   endfunction

endpackage

// ===== hdl/frc_if.sv =====
`timescale 1ns / 1ps

interface frc_req_if import frc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SEQ_WIDTH-1:0]    seq_number;
   logic [ID_WIDTH-1:0]     packet_id;
   logic                    more_flag;
   logic [OFFSET_WIDTH-1:0] end_offset;
   logic [OFFSET_WIDTH-1:0] frag_length;
   logic                    last_item;

   modport source (
      output valid, seq_number, packet_id, more_flag, end_offset, frag_length, last_item,
      input  ready
   );
   modport sink (
      input  valid, seq_number, packet_id, more_flag, end_offset, frag_length, last_item,
      output ready
   );
endinterface

interface frc_rsp_if import frc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   verdict_type           verdict;
   logic [SIZE_WIDTH-1:0] total_size;

   modport source (
      output valid, verdict, total_size,
      input  ready
   );
   modport sink (
      input  valid, verdict, total_size,
      output ready
   );
endinterface

// ===== hdl/fragment_reassembly_checker.sv =====
`timescale 1ns / 1ps
// a last item waits in the input register; its result goes to the result register
// throughput: one item per cycle; input and result registers decouple the two
// channels, so a stalled result holds only a last item in the input register
// reset: synchronous, active high; clears both stage valids and the packet state
// (fragment count, offset and sticky error bits) so the next item starts a packet

module fragment_reassembly_checker import frc_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input logic   clock,
   input logic   reset,
   frc_req_if.sink   req_chan,
   frc_rsp_if.source rsp_chan
);

   // offsets wider than the port carry nothing extra
   localparam int OB = (OFFSET_BITS < OFFSET_WIDTH) ? OFFSET_BITS : OFFSET_WIDTH;

   // input register
   logic                    in_valid_ff;
   logic [SEQ_WIDTH-1:0]    in_seq_ff;
   logic [ID_WIDTH-1:0]     in_id_ff;
   logic                    in_more_ff;
   logic [OB-1:0]           in_end_ff;
   logic [OB-1:0]           in_len_ff;
   logic                    in_last_ff;

   // packet state
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [ID_WIDTH-1:0]     first_id_ff, first_id_in;
   logic [OB-1:0]           first_len_ff, first_len_in;
   logic [OB-1:0]           prev_end_ff, prev_end_in;
   err_flags_type           err_ff, err_in;

   // result register
   logic                    out_valid_ff, out_valid_in;
   verdict_type             out_verdict_ff, out_verdict_in;
   logic [SIZE_WIDTH-1:0]   out_size_ff, out_size_in;

   logic                    advance;
   logic                    accept;
   logic                    is_first;
   logic [ID_WIDTH-1:0]     ref_id;
   logic [OB-1:0]           ref_len;
   logic [COUNT_WIDTH:0]    expected_seq;
   logic [OB:0]             offset_sum;
   err_flags_type           new_err;
   err_flags_type           all_err;
   verdict_type             verdict;

   // an item without a result never needs the output slot
   assign advance = in_valid_ff &&
                    (!in_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      is_first     = (count_ff == '0);
      ref_id       = is_first ? in_id_ff  : first_id_ff;
      ref_len      = is_first ? in_len_ff : first_len_ff;
      expected_seq = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(1);
      offset_sum   = {1'b0, prev_end_ff} + {1'b0, in_len_ff};

      new_err             = '0;
      new_err[ERR_SEQ]    = ((COUNT_WIDTH + 1)'(in_seq_ff) != expected_seq);
      new_err[ERR_ID]     = (in_id_ff != ref_id);
      new_err[ERR_FLAG]   = in_last_ff ? in_more_ff : !in_more_ff;
      new_err[ERR_LENGTH] = !in_last_ff && (in_len_ff != ref_len);
      new_err[ERR_OFFSET] = ({1'b0, in_end_ff} != offset_sum);
      all_err             = err_ff | new_err;
      verdict             = lowest_error(all_err);

      count_in       = count_ff;
      first_id_in    = first_id_ff;
      first_len_in   = first_len_ff;
      prev_end_in    = prev_end_ff;
      err_in         = err_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_verdict_in = out_verdict_ff;
      out_size_in    = out_size_ff;

      if (advance) begin
         if (in_last_ff) begin
            // packet done: hand out the verdict and start over
            count_in       = '0;
            first_id_in    = '0;
            first_len_in   = '0;
            prev_end_in    = '0;
            err_in         = '0;
            out_valid_in   = 1'b1;
            out_verdict_in = verdict;
            out_size_in    = (verdict == VERDICT_OK) ? SIZE_WIDTH'(in_end_ff) : '0;
         end else begin
            if (count_ff != '1) begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
            first_id_in  = ref_id;
            first_len_in = ref_len;
            prev_end_in  = in_end_ff;
            err_in       = all_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         first_id_ff  <= '0;
         first_len_ff <= '0;
         prev_end_ff  <= '0;
         err_ff       <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         first_id_ff  <= first_id_in;
         first_len_ff <= first_len_in;
         prev_end_ff  <= prev_end_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_seq_ff  <= req_chan.seq_number;
         in_id_ff   <= req_chan.packet_id;
         in_more_ff <= req_chan.more_flag;
         in_end_ff  <= req_chan.end_offset[OB-1:0];
         in_len_ff  <= req_chan.frag_length[OB-1:0];
         in_last_ff <= req_chan.last_item;
      end
      out_verdict_ff <= out_verdict_in;
      out_size_ff    <= out_size_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.verdict    = out_verdict_ff;
   assign rsp_chan.total_size = out_size_ff;

endmodule

// ===== hdl/frc_checker.sv =====
`timescale 1ns / 1ps

module frc_checker import frc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last_item,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input verdict_type           rsp_verdict,
   input logic [SIZE_WIDTH-1:0] rsp_total_size
);

   // no result is left over once reset has been seen
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) && $stable(rsp_total_size))
      else $error("stalled result changed");

   // a fresh result comes from a last item that passed the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_item, 2))
      else $error("result without a last item");

   // a failed packet reports no size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_size != '0 |-> rsp_verdict == VERDICT_OK)
      else $error("size reported on a failed packet");

endmodule

bind fragment_reassembly_checker frc_checker u_frc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_last_item  (req_chan.last_item),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_verdict    (rsp_chan.verdict),
   .rsp_total_size (rsp_chan.total_size)
);
